// ===== design/assert_macros.svh =====
// Assertion macros for the port-level checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define LPRW_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Clocked property that also holds while reset is asserted.
`define LPRW_ASSERT_ANY(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== design/lprw_pkg.sv =====
// Package for the lattice random walk block: item types, codes and controller states.
`default_nettype none

package lprw_pkg;

    // Fixed field widths
    localparam int CELL_W  = 10;
    localparam int COUNT_W = 10;
    localparam int DIR_W   = 3;
    localparam int STAT_W  = 2;
    localparam int SUM_W   = COUNT_W + 1;
    // Wide enough for any cell number or particle limit in the parameter range
    localparam int WIDE_W  = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MOVE  = 1'b1;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;
    localparam logic [DIR_W-1:0] DIR_STAY  = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_MOVED     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_STAYED    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_WRITE     = 2'd3;

    typedef struct packed {
        logic               command;
        logic [CELL_W-1:0]  cell_index;
        logic [COUNT_W-1:0] cell_value;
        logic [COUNT_W-1:0] particle_rank;
        logic [DIR_W-1:0]   direction;
    } in_item_t;

    typedef struct packed {
        logic [CELL_W-1:0] source_cell;
        logic [CELL_W-1:0] dest_cell;
        logic [STAT_W-1:0] status;
    } out_item_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SRC_WR,
        S_DST_WR,
        S_FINISH
    } lprw_state_t;

endpackage

`default_nettype wire

// ===== design/lprw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lprw_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/lattice_particle_random_walk_unit.sv =====
// Top level of the lattice random walk block: controller around the cell count RAM.
//
// Usage:
//   Input channel item/item_valid/item_stall carries one command per item.
//   A write item loads one cell count; a move item picks the particle of
//   the given rank by a row-major scan and moves it one step with
//   wrap-around; any code but the four moves leaves it in place. Each item
//   gives exactly one result on result/result_valid/result_stall, through
//   an output register. Flow: a write item passes from S_IDLE through
//   S_FINISH into the output register. A move item scans one cell count per
//   cycle from the RAM read port; a stay or not-found result then goes to
//   S_FINISH, and a move first adds the read-modify-write of source and
//   destination in S_SRC_WR and S_DST_WR. One item is in work at a time;
//   the next is accepted as soon as the current result sits in the output
//   register. Reset: after rst_n rises, a clearing pass writes zero to
//   every cell, with item_stall high.
//   A stalled result holds the output register; a finished item then waits
//   in the controller until the register frees, and item_stall stays high.
`default_nettype none

module lattice_particle_random_walk_unit
    import lprw_pkg::*;
#(
    parameter int GRID_SIDE     = 32,
    parameter int MAX_PARTICLES = 1023
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SIDE_W = $clog2(GRID_SIDE);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SIDE_A    = ADDR_W'(GRID_SIDE);
    localparam logic [ADDR_W-1:0] SIDE_M1   = ADDR_W'(GRID_SIDE - 1);
    localparam logic [ADDR_W-1:0] WRAP_ROW  = ADDR_W'(CELLS - GRID_SIDE);
    localparam logic [SIDE_W-1:0] LAST_POS  = SIDE_W'(GRID_SIDE - 1);
    localparam logic [WIDE_W-1:0] CELLS_W   = WIDE_W'(CELLS);
    localparam logic [WIDE_W-1:0] MAX_RANK  = WIDE_W'(MAX_PARTICLES);

    // Control registers
    lprw_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              iss_done_reg, iss_done_next;
    logic              chk_valid_reg, chk_valid_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    logic [COUNT_W-1:0] rank_reg, rank_next;
    logic [DIR_W-1:0]   dir_reg, dir_next;
    logic [ADDR_W-1:0]  iss_addr_reg, iss_addr_next;
    logic [SIDE_W-1:0]  iss_row_reg, iss_row_next;
    logic [SIDE_W-1:0]  iss_col_reg, iss_col_next;
    logic [ADDR_W-1:0]  chk_addr_reg, chk_addr_next;
    logic [SIDE_W-1:0]  chk_row_reg, chk_row_next;
    logic [SIDE_W-1:0]  chk_col_reg, chk_col_next;
    logic               chk_last_reg, chk_last_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [ADDR_W-1:0]  src_reg, src_next;
    logic [ADDR_W-1:0]  dst_reg, dst_next;
    logic [COUNT_W-1:0] src_cnt_reg, src_cnt_next;
    out_item_t          res_reg, res_next;
    out_item_t          out_reg, out_next;

    // RAM port signals
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [COUNT_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [COUNT_W-1:0] ram_rd_data;

    // Helpers
    logic [WIDE_W-1:0]  idx_wide;
    logic [WIDE_W-1:0]  rank_wide;
    logic [WIDE_W-1:0]  chk_wide;
    logic [WIDE_W-1:0]  src_wide;
    logic [WIDE_W-1:0]  dst_wide;
    logic [SUM_W-1:0]   sum_add;
    logic [ADDR_W-1:0]  dst_calc;
    logic               dir_moves;
    logic               out_free;

    assign idx_wide  = WIDE_W'(item.cell_index);
    assign rank_wide = WIDE_W'(item.particle_rank);
    assign chk_wide  = WIDE_W'(chk_addr_reg);
    assign src_wide  = WIDE_W'(src_reg);
    assign dst_wide  = WIDE_W'(dst_reg);
    assign sum_add   = sum_reg + SUM_W'(ram_rd_data);
    assign out_free  = !out_valid_reg || !result_stall;

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Neighbor address of the checked cell, wrapped at the grid edges
    always_comb
    begin
        dst_calc  = chk_addr_reg;
        dir_moves = 1'b1;
        unique case (dir_reg)
            DIR_UP:
                dst_calc = (chk_row_reg == '0) ? chk_addr_reg + WRAP_ROW
                                               : chk_addr_reg - SIDE_A;
            DIR_DOWN:
                dst_calc = (chk_row_reg == LAST_POS) ? chk_addr_reg - WRAP_ROW
                                                     : chk_addr_reg + SIDE_A;
            DIR_LEFT:
                dst_calc = (chk_col_reg == '0) ? chk_addr_reg + SIDE_M1
                                               : chk_addr_reg - ADDR_W'(1);
            DIR_RIGHT:
                dst_calc = (chk_col_reg == LAST_POS) ? chk_addr_reg - SIDE_M1
                                                     : chk_addr_reg + ADDR_W'(1);
            default:
                dir_moves = 1'b0;
        endcase
    end

    // Controller: next state, RAM accesses, result forming
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        iss_done_next  = iss_done_reg;
        chk_valid_next = 1'b0;
        out_valid_next = out_valid_reg && result_stall;
        rank_next      = rank_reg;
        dir_next       = dir_reg;
        iss_addr_next  = iss_addr_reg;
        iss_row_next   = iss_row_reg;
        iss_col_next   = iss_col_reg;
        chk_addr_next  = iss_addr_reg;
        chk_row_next   = iss_row_reg;
        chk_col_next   = iss_col_reg;
        chk_last_next  = (iss_addr_reg == LAST_ADDR);
        sum_next       = sum_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        src_cnt_next   = src_cnt_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = src_reg;
        ram_wr_data    = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = iss_addr_reg;

        unique case (state_reg)
            // Zero every cell after reset
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_data = '0;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end

            // Take one item
            S_IDLE:
            begin
                if (item_valid)
                begin
                    rank_next = item.particle_rank;
                    dir_next  = item.direction;
                    if (item.command == CMD_WRITE)
                    begin
                        ram_wr_en   = (idx_wide < CELLS_W);
                        ram_wr_addr = idx_wide[ADDR_W-1:0];
                        ram_wr_data = item.cell_value;
                        res_next    = '{source_cell: item.cell_index,
                                        dest_cell:   item.cell_index,
                                        status:      STAT_WRITE};
                        state_next  = S_FINISH;
                    end
                    else if (item.particle_rank == '0 || rank_wide > MAX_RANK)
                    begin
                        res_next   = '{source_cell: '0, dest_cell: '0,
                                       status: STAT_NOT_FOUND};
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        iss_addr_next = '0;
                        iss_row_next  = '0;
                        iss_col_next  = '0;
                        iss_done_next = 1'b0;
                        sum_next      = '0;
                        state_next    = S_SCAN;
                    end
                end
            end

            // One read issued and one count checked per cycle
            S_SCAN:
            begin
                ram_rd_en      = !iss_done_reg;
                ram_rd_addr    = iss_addr_reg;
                chk_valid_next = !iss_done_reg;
                if (iss_addr_reg == LAST_ADDR)
                begin
                    iss_done_next = 1'b1;
                end
                else
                begin
                    iss_addr_next = iss_addr_reg + ADDR_W'(1);
                    if (iss_col_reg == LAST_POS)
                    begin
                        iss_col_next = '0;
                        iss_row_next = iss_row_reg + SIDE_W'(1);
                    end
                    else
                    begin
                        iss_col_next = iss_col_reg + SIDE_W'(1);
                    end
                end

                if (chk_valid_reg)
                begin
                    sum_next = sum_add;
                    if (sum_add >= SUM_W'(rank_reg))
                    begin
                        chk_valid_next = 1'b0;
                        src_next       = chk_addr_reg;
                        dst_next       = dst_calc;
                        src_cnt_next   = ram_rd_data;
                        if (dir_moves)
                        begin
                            state_next = S_SRC_WR;
                        end
                        else
                        begin
                            res_next   = '{source_cell: chk_wide[CELL_W-1:0],
                                           dest_cell:   chk_wide[CELL_W-1:0],
                                           status:      STAT_STAYED};
                            state_next = S_FINISH;
                        end
                    end
                    else if (chk_last_reg)
                    begin
                        chk_valid_next = 1'b0;
                        res_next   = '{source_cell: '0, dest_cell: '0,
                                       status: STAT_NOT_FOUND};
                        state_next = S_FINISH;
                    end
                end
            end

            // Take the particle from the source, fetch the destination count
            S_SRC_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = src_reg;
                ram_wr_data = src_cnt_reg - COUNT_W'(1);
                ram_rd_en   = 1'b1;
                ram_rd_addr = dst_reg;
                state_next  = S_DST_WR;
            end

            // Saturating increment at the destination
            S_DST_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = dst_reg;
                ram_wr_data = (ram_rd_data == COUNT_MAX) ? ram_rd_data
                                                         : ram_rd_data + COUNT_W'(1);
                res_next    = '{source_cell: src_wide[CELL_W-1:0],
                                dest_cell:   dst_wide[CELL_W-1:0],
                                status:      STAT_MOVED};
                state_next  = S_FINISH;
            end

            // Hand the result to the output register once it frees
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            iss_done_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            iss_done_reg  <= iss_done_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        rank_reg     <= rank_next;
        dir_reg      <= dir_next;
        iss_addr_reg <= iss_addr_next;
        iss_row_reg  <= iss_row_next;
        iss_col_reg  <= iss_col_next;
        chk_addr_reg <= chk_addr_next;
        chk_row_reg  <= chk_row_next;
        chk_col_reg  <= chk_col_next;
        chk_last_reg <= chk_last_next;
        sum_reg      <= sum_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        src_cnt_reg  <= src_cnt_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    // Cell count store
    lprw_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (CELLS)
    ) u_counts (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ===== design/lprw_checker.sv =====
// Port-level checker for the lattice random walk block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module lprw_checker
    import lprw_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      item_valid,
    input wire logic      item_stall,
    input wire in_item_t  item,
    input wire logic      result_valid,
    input wire logic      result_stall,
    input wire out_item_t result
);

    logic res_held;
    logic item_taken;
    logic res_one_cell;
    logic res_same;

    assign res_held     = result_valid && result_stall;
    assign item_taken   = item_valid && !item_stall;
    assign res_one_cell = (result.status == STAT_WRITE) || (result.status == STAT_STAYED);
    assign res_same     = (result.source_cell == result.dest_cell);

    // A stalled result stays offered and unchanged
    `LPRW_ASSERT(a_res_hold_valid, clk, rst_n, (res_held |=> result_valid), "stalled result dropped")
    `LPRW_ASSERT(a_res_hold_data, clk, rst_n, (res_held |=> $stable(result)), "stalled result changed")

    // Only one item in work: the block is busy right after an accept
    `LPRW_ASSERT(a_one_in_work, clk, rst_n, (item_taken |=> item_stall), "item accepted while busy")

    // Write and stay results name one cell
    `LPRW_ASSERT(a_same_cell, clk, rst_n, (result_valid && res_one_cell |-> res_same), "cells differ")

    // No result leaves during reset
    `LPRW_ASSERT_ANY(a_reset_quiet, clk, (!rst_n |-> result_valid !== 1'b1), "result during reset")

endmodule

bind lattice_particle_random_walk_unit lprw_checker u_lprw_checker (.*);

`default_nettype wire

// ===== test/lprw_walk_checker.sv =====
// Checker for the lattice random walk block: predicts every result and compares it.
`timescale 1ns / 1ps

module lprw_walk_checker
    import lprw_pkg::*;
#(
    parameter int GRID_SIDE     = 32,
    parameter int MAX_PARTICLES = 1023
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_stall,
    input  in_item_t  item,
    input  logic      result_valid,
    input  logic      result_stall,
    input  out_item_t result,
    output int        fails,
    output int        pending
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;

    // Own copy of the particle counts, one entry per cell
    logic [COUNT_W-1:0] lattice [CELLS];
    out_item_t          walk_results [$];
    out_item_t          oldest;
    int                 fail_total = 0;
    int                 queued     = 0;

    assign fails   = fail_total;
    assign pending = queued;

    // One line per mismatch, and count it
    task automatic report_mismatch(input string note);
        $display("%0t ns: mismatch: %s", $time, note);
        fail_total++;
    endtask

    // Apply one item to the lattice copy and return the result it gives
    function automatic out_item_t walk_step(input in_item_t it);
        out_item_t   r;
        int unsigned tally;
        int unsigned scan_pos;
        int unsigned src;
        int unsigned row;
        int unsigned col;
        int unsigned dst;
        bit          hit;
        r     = '0;
        tally = 0;
        src   = 0;
        hit   = 1'b0;

        if (it.command == CMD_WRITE) begin
            // out-of-grid writes are dropped but still answered
            if (it.cell_index < CELLS)
                lattice[it.cell_index] = it.cell_value;
            r.source_cell = it.cell_index;
            r.dest_cell   = it.cell_index;
            r.status      = STAT_WRITE;
            return r;
        end

        // row-major scan until the running count reaches the rank
        if (it.particle_rank != 0 && it.particle_rank <= MAX_PARTICLES) begin
            scan_pos = 0;
            while (!hit && scan_pos < CELLS) begin
                tally += lattice[scan_pos];
                if (tally >= it.particle_rank) begin
                    src = scan_pos;
                    hit = 1'b1;
                end
                scan_pos++;
            end
        end
        if (!hit) begin
            r.status = STAT_NOT_FOUND;
            return r;
        end

        row = src / GRID_SIDE;
        col = src % GRID_SIDE;
        case (it.direction)
            DIR_UP:    row = (row == 0) ? GRID_SIDE - 1 : row - 1;
            DIR_DOWN:  row = (row == GRID_SIDE - 1) ? 0 : row + 1;
            DIR_LEFT:  col = (col == 0) ? GRID_SIDE - 1 : col - 1;
            DIR_RIGHT: col = (col == GRID_SIDE - 1) ? 0 : col + 1;
            default:
            begin
                // stay, and any code outside the four moves
                r.source_cell = CELL_W'(src);
                r.dest_cell   = CELL_W'(src);
                r.status      = STAT_STAYED;
                return r;
            end
        endcase
        dst = row * GRID_SIDE + col;

        // source always loses the particle; a full destination saturates
        lattice[src] = lattice[src] - 1'b1;
        if (lattice[dst] != COUNT_MAX)
            lattice[dst] = lattice[dst] + 1'b1;
        r.source_cell = CELL_W'(src);
        r.dest_cell   = CELL_W'(dst);
        r.status      = STAT_MOVED;
        return r;
    endfunction

    // Watch both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CELLS; c++)
                lattice[c] = '0;
            walk_results.delete();
            queued = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (walk_results.size() == 0)
                    report_mismatch($sformatf("result with no item pending: src %0d dst %0d st %0d",
                        result.source_cell, result.dest_cell, result.status));
                else
                begin
                    oldest = walk_results.pop_front();
                    if (result.source_cell !== oldest.source_cell)
                        report_mismatch($sformatf("source_cell got %0d expected %0d",
                            result.source_cell, oldest.source_cell));
                    if (result.dest_cell !== oldest.dest_cell)
                        report_mismatch($sformatf("dest_cell got %0d expected %0d",
                            result.dest_cell, oldest.dest_cell));
                    if (result.status !== oldest.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                            result.status, oldest.status));
                end
            end
            if (item_valid && !item_stall)
                walk_results.push_back(walk_step(item));
            queued = walk_results.size();
        end
    end

endmodule

// ===== test/tb_lattice_particle_random_walk_unit.sv =====
// Testbench top for the lattice random walk block: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_lattice_particle_random_walk_unit;
    import lprw_pkg::*;

    localparam int GRID_SIDE     = 32;
    localparam int MAX_PARTICLES = 1023;
    localparam int CELLS         = GRID_SIDE * GRID_SIDE;
    localparam int QUIET_LIMIT   = 12000;
    localparam int HOLD_CYCLES   = 400;

    logic      clk;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;
    int        fails;
    int        pending;

    // Stimulus knobs shared with the receiver process
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int sent      = 0;
    int quiet     = 0;

    // Rough count of planted particles, from writes only; steers the ranks
    int planted = 0;
    int planted_at [CELLS];

    lattice_particle_random_walk_unit #(
        .GRID_SIDE     (GRID_SIDE),
        .MAX_PARTICLES (MAX_PARTICLES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    lprw_walk_checker #(
        .GRID_SIDE     (GRID_SIDE),
        .MAX_PARTICLES (MAX_PARTICLES)
    ) walk_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fails        (fails),
        .pending      (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: long hold-off when asked, else random stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Write item; the unused fields carry random bits
    function automatic in_item_t write_item(input int idx, input int val);
        in_item_t x;
        x.command       = CMD_WRITE;
        x.cell_index    = CELL_W'(idx);
        x.cell_value    = COUNT_W'(val);
        x.particle_rank = COUNT_W'($urandom_range(1023));
        x.direction     = DIR_W'($urandom_range(7));
        return x;
    endfunction

    // Move item; the unused fields carry random bits
    function automatic in_item_t move_item(input int rank, input int dir);
        in_item_t x;
        x.command       = CMD_MOVE;
        x.cell_index    = CELL_W'($urandom_range(1023));
        x.cell_value    = COUNT_W'($urandom_range(1023));
        x.particle_rank = COUNT_W'(rank);
        x.direction     = DIR_W'(dir);
        return x;
    endfunction

    // Offer one item from a falling edge and return at the falling edge after it is taken
    task automatic send_item(input in_item_t x);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= x;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
        sent++;
        if (x.command == CMD_WRITE && x.cell_index < CELLS)
        begin
            planted += int'(x.cell_value) - planted_at[x.cell_index];
            planted_at[x.cell_index] = x.cell_value;
        end
    endtask

    // A few writes to random cells, then moves of mostly existing particles, now and then a random item
    task automatic random_episode();
        int       n_writes;
        int       n_moves;
        int       val;
        int       rank;
        int       dir;
        int       cap;
        int       pick;
        in_item_t noise;
        n_writes = $urandom_range(1, 5);
        n_moves  = $urandom_range(2, 8);
        repeat (n_writes)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                val = 0;
            else if (pick < 90)
                val = $urandom_range(1, 40);
            else
                val = $urandom_range(1023);
            send_item(write_item($urandom_range(CELLS - 1), val));
        end
        repeat (n_moves)
        begin
            cap  = (planted > 1023) ? 1023 : ((planted < 1) ? 1 : planted);
            pick = $urandom_range(99);
            if (pick < 80)
                rank = $urandom_range(1, cap);
            else if (pick < 90 || planted >= 1023)
                rank = $urandom_range(1023);
            else
                rank = $urandom_range(planted + 1, 1023);
            if ($urandom_range(99) < 85)
                dir = $urandom_range(DIR_UP, DIR_RIGHT);
            else
                dir = $urandom_range(7);
            send_item(move_item(rank, dir));
        end
        // occasional item with every field random
        if ($urandom_range(9) == 0)
        begin
            noise         = move_item($urandom_range(1023), $urandom_range(7));
            noise.command = 1'($urandom_range(1));
            send_item(noise);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int quota);
        int start;
        idle_pct  = idle;
        stall_pct = stall;
        start     = sent;
        while (sent - start < quota)
            random_episode();
    endtask

    // Stimulus and verdict
    initial
    begin
        for (int c = 0; c < CELLS; c++)
            planted_at[c] = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty grid, rank zero, wrap on every edge, all stay codes
        send_item(move_item(1, DIR_UP));
        send_item(move_item(0, DIR_DOWN));
        send_item(write_item(0, 5));
        send_item(write_item(31, 3));
        send_item(write_item(992, 2));
        send_item(write_item(CELLS - 1, 1023));
        send_item(move_item(1, DIR_UP));
        send_item(move_item(1, DIR_LEFT));
        send_item(move_item(4, DIR_RIGHT));
        send_item(move_item(8, DIR_DOWN));
        send_item(move_item(9, DIR_STAY));
        // codes outside the five directions also stay
        send_item(move_item(9, 0));
        send_item(move_item(9, 6));
        send_item(move_item(9, 7));
        send_item(move_item(1023, DIR_DOWN));
        // bottom-left corner cell moves left into the bottom-right corner, which it fills
        send_item(move_item(10, DIR_LEFT));
        send_item(write_item(CELLS - 1, 0));
        send_item(move_item(1023, DIR_RIGHT));
        send_item(move_item(11, DIR_RIGHT));
        send_item(write_item(33, 1023));

        run_phase(0, 0, 135);

        // Receiver holds off while writes keep coming, so the input backs up
        item_valid <= 1'b0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
        repeat (24)
            send_item(write_item($urandom_range(CELLS - 1), $urandom_range(1023)));

        run_phase(74, 0, 135);
        run_phase(0, 74, 135);
        run_phase(38, 38, 135);

        // Drain, then let a full move time pass
        item_valid <= 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (1100) @(posedge clk);

        if (fails == 0 && pending == 0)
            $display("lattice_particle_random_walk_unit regression: pass");
        else
            $display("lattice_particle_random_walk_unit regression: fail");
        $finish;
    end

    // Watchdog: too long with no item taken on either channel
    initial
    begin
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("lattice_particle_random_walk_unit regression: fail");
        $finish;
    end

endmodule
